FILE: sv/fid_pkg.sv
// Shared constants and types for the FIFO identifier allocator.
`default_nettype none

package fid_pkg;

    localparam int ID_COUNT = 64;
    localparam int TAG_BITS = 32;

    localparam int ID_ADDR_BITS = $clog2(ID_COUNT);
    localparam int COUNT_BITS   = $clog2(ID_COUNT + 1);

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_SET_TAG = 2'd2,
        KIND_GET_TAG = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NONE_FREE = 2'd1,
        STATUS_LIST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } fsm_state_t;

endpackage

`default_nettype wire

FILE: sv/fid_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/fifo_id_allocator_with_tags.sv
// Top level of the FIFO free-list identifier allocator with per-identifier tags.
//
//  Channel  Direction  Handshake            Word
//  in       sink       in_valid / in_stall  kind, id, tag_in
//  out      source     out_valid / out_stall new_id, tag_out, active_now, status
//
// Each request first reads the free-list and tag RAMs when it is accepted,
// then updates them and loads the result register in ST_EXEC.
// A new request is taken in the cycle after the previous one completes.
// Reset frees every identifier and clears every tag; per-entry valid bits stand
// in for the reset contents of both RAMs, so no clearing pass is needed.
// A result held by out_stall keeps the next request waiting in ST_EXEC.
`default_nettype none

module fifo_id_allocator_with_tags #(
    parameter int ID_COUNT = fid_pkg::ID_COUNT,
    parameter int TAG_BITS = fid_pkg::TAG_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [5:0]  id,
    input  wire logic [31:0] tag_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       new_id,
    output logic [31:0]      tag_out,
    output logic [6:0]       active_now,
    output logic [1:0]       status
);

    localparam int IdCount = ID_COUNT;
    localparam int TagBits = TAG_BITS;
    localparam int Aw      = $clog2(ID_COUNT);
    localparam int Cw      = $clog2(ID_COUNT + 1);
    localparam logic [Aw-1:0] LastSlot = Aw'(IdCount - 1);
    localparam logic [Cw-1:0] FullCount = Cw'(IdCount);

    fid_pkg::fsm_state_t state_reg, state_next;

    logic [Aw-1:0]      head_reg, head_next;
    logic [Aw-1:0]      tail_reg, tail_next;
    logic [Cw-1:0]      active_reg, active_next;
    logic [IdCount-1:0] fl_written_reg, fl_written_next;
    logic [IdCount-1:0] tag_written_reg, tag_written_next;
    logic               out_valid_reg, out_valid_next;

    logic [1:0]         kind_reg;
    logic [5:0]         id_reg;
    logic [TagBits-1:0] tag_reg;

    logic [5:0]  new_id_reg, new_id_next;
    logic [31:0] tag_out_reg, tag_out_next;
    logic [6:0]  active_now_reg;
    logic [1:0]  status_reg, status_next;

    logic               accept;
    logic               finish;
    logic               id_ok;
    logic [Aw-1:0]      id_addr;

    logic               fl_wr_en;
    logic [Aw-1:0]      fl_rdata;
    logic               tag_wr_en;
    logic [TagBits-1:0] tag_wr_data;
    logic [TagBits-1:0] tag_rdata;

    assign in_stall   = (state_reg != fid_pkg::ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign finish     = (state_reg == fid_pkg::ST_EXEC) && (!out_valid_reg || !out_stall);

    assign out_valid  = out_valid_reg;
    assign new_id     = new_id_reg;
    assign tag_out    = tag_out_reg;
    assign active_now = active_now_reg;
    assign status     = status_reg;

    assign id_ok   = (13'(id_reg) < 13'(IdCount));
    assign id_addr = id_reg[Aw-1:0];

    // The free list is read at the head and the tag table at the request's id.
    fid_ram #(
        .WIDTH(Aw),
        .DEPTH(IdCount)
    ) u_free_list (
        .clk     (clk),
        .wr_en   (fl_wr_en),
        .wr_addr (tail_reg),
        .wr_data (id_addr),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (fl_rdata)
    );

    fid_ram #(
        .WIDTH(TagBits),
        .DEPTH(IdCount)
    ) u_tag_table (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (id_addr),
        .wr_data (tag_wr_data),
        .rd_en   (accept),
        .rd_addr (id[Aw-1:0]),
        .rd_data (tag_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        active_next      = active_reg;
        fl_written_next  = fl_written_reg;
        tag_written_next = tag_written_reg;
        out_valid_next   = out_valid_reg && out_stall;
        fl_wr_en         = 1'b0;
        tag_wr_en        = 1'b0;
        tag_wr_data      = tag_reg;
        new_id_next      = '0;
        tag_out_next     = '0;
        status_next      = fid_pkg::STATUS_OK;

        case (state_reg)
            fid_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = fid_pkg::ST_EXEC;
                end
            end
            fid_pkg::ST_EXEC:
            begin
                if (finish)
                begin
                    state_next     = fid_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    case (kind_reg)
                        fid_pkg::KIND_ALLOC:
                        begin
                            if (active_reg == FullCount)
                            begin
                                status_next = fid_pkg::STATUS_NONE_FREE;
                            end
                            else
                            begin
                                // An entry never written is taken to hold its own index.
                                new_id_next = 6'(fl_written_reg[head_reg] ? fl_rdata : head_reg);
                                head_next   = (head_reg == LastSlot) ? '0 : head_reg + 1'b1;
                                active_next = active_reg + 1'b1;
                            end
                        end
                        fid_pkg::KIND_RELEASE:
                        begin
                            if (id_ok)
                            begin
                                if (active_reg == '0)
                                begin
                                    status_next = fid_pkg::STATUS_LIST_FULL;
                                end
                                else
                                begin
                                    tag_wr_en                 = 1'b1;
                                    tag_wr_data               = '0;
                                    tag_written_next[id_addr] = 1'b1;
                                    fl_wr_en                  = 1'b1;
                                    fl_written_next[tail_reg] = 1'b1;
                                    tail_next   = (tail_reg == LastSlot) ? '0 : tail_reg + 1'b1;
                                    active_next = active_reg - 1'b1;
                                end
                            end
                        end
                        fid_pkg::KIND_SET_TAG:
                        begin
                            if (id_ok)
                            begin
                                tag_wr_en                 = 1'b1;
                                tag_written_next[id_addr] = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (id_ok && tag_written_reg[id_addr])
                            begin
                                tag_out_next = 32'(tag_rdata);
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = fid_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fid_pkg::ST_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            active_reg      <= '0;
            fl_written_reg  <= '0;
            tag_written_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            active_reg      <= active_next;
            fl_written_reg  <= fl_written_next;
            tag_written_reg <= tag_written_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            id_reg   <= id;
            tag_reg  <= tag_in[TagBits-1:0];
        end
        if (finish)
        begin
            new_id_reg     <= new_id_next;
            tag_out_reg    <= tag_out_next;
            active_now_reg <= 7'(active_next);
            status_reg     <= status_next;
        end
    end

endmodule

`default_nettype wire
